// File: rtl/core/pcxrle_pkg.sv
package pcxrle_pkg;

    localparam int MAX_LINE_BYTES = 2048;
    localparam int LINE_AW        = $clog2(MAX_LINE_BYTES);
    localparam int LINE_DEPTH     = 2 ** LINE_AW;
    localparam int BPL_W          = 12;
    localparam int HGT_W          = 16;
    localparam int CNT_W          = 6;
    localparam int CFG_AW         = 2;
    localparam int CFG_DW         = 16;
    localparam int PAL_DEPTH      = 256;

    // Input item modes
    localparam logic [1:0] MODE_DATA  = 2'd0;
    localparam logic [1:0] MODE_PAL   = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_BPL    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_HEIGHT = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_THREE  = 2'd3;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam logic [1:0] MARKER_TAG = 2'b11;

    typedef struct packed {
        logic start;
        logic pal_wr;
        logic expand;
        logic step;
        logic set_pend;
        logic err;
    } ctl_cmd_t;

    typedef struct packed {
        logic adv;
        logic blocked;
        logic pending;
        logic marker;
        logic zero_cnt;
        logic iter_done;
    } dp_stat_t;

endpackage

// File: rtl/core/pcxrle_if.sv
interface pcxrle_in_if;
    import pcxrle_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;

    modport source (output valid, mode, data_byte, palette_index, palette_color, input ready);
    modport sink (input valid, mode, data_byte, palette_index, palette_color, output ready);
endinterface

interface pcxrle_out_if;
    import pcxrle_pkg::*;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_run;
    logic       last_of_image;

    modport source (output valid, kind, red, green, blue, last_of_run, last_of_image,
                    input ready);
    modport sink (input valid, kind, red, green, blue, last_of_run, last_of_image,
                  output ready);
endinterface

interface pcxrle_cfg_if;
    import pcxrle_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] reg_index;
    logic [CFG_DW-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/core/pcxrle_ctrl.sv
module pcxrle_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            in_mode,
    input  pcxrle_pkg::dp_stat_t  stat,
    output logic                  in_ready,
    output pcxrle_pkg::ctl_cmd_t  cmd
);
    import pcxrle_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == ST_IDLE) && stat.adv;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (in_mode)
                        MODE_START: cmd.start  = 1'b1;
                        MODE_PAL:   cmd.pal_wr = 1'b1;
                        MODE_DATA:
                        begin
                            if (!stat.blocked)
                            begin
                                if (stat.pending)
                                    cmd.expand = 1'b1;
                                else if (stat.marker)
                                begin
                                    if (stat.zero_cnt)
                                        cmd.err = 1'b1;
                                    else
                                        cmd.set_pend = 1'b1;
                                end
                                else
                                    cmd.expand = 1'b1;
                                // first byte goes out now, stay on for the rest of the run
                                if (cmd.expand && !stat.iter_done)
                                    state_next = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                if (stat.adv)
                begin
                    cmd.step = 1'b1;
                    if (stat.iter_done)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/core/pcxrle_datapath.sv
module pcxrle_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            data_byte,
    input  logic [7:0]            palette_index,
    input  logic [23:0]           palette_color,
    input  pcxrle_pkg::ctl_cmd_t  cmd,
    output pcxrle_pkg::dp_stat_t  stat,
    pcxrle_out_if.source          out_ch,
    pcxrle_cfg_if.sink            cfg_ch
);
    import pcxrle_pkg::*;

    // configuration
    logic [BPL_W-1:0] bpl_reg;
    logic [BPL_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic             three_reg;

    // decoder state
    logic [BPL_W-1:0] pos_reg;
    logic [1:0]       plane_reg;
    logic [HGT_W-1:0] lines_reg;
    logic             pend_reg;
    logic [CNT_W-1:0] runcnt_reg;
    logic             halt_reg;
    logic [7:0]       data_reg;
    logic [CNT_W-1:0] rem_reg;

    // stores
    logic [23:0] pal_mem   [PAL_DEPTH];
    logic [7:0]  line0_mem [LINE_DEPTH];
    logic [7:0]  line1_mem [LINE_DEPTH];
    logic [23:0] pal_q;
    logic [7:0]  line0_q;
    logic [7:0]  line1_q;

    // read stage and output register
    logic       s1_valid_reg;
    logic       s1_kind_reg;
    logic       s1_three_reg;
    logic [7:0] s1_blue_reg;
    logic       s1_last_run_reg;
    logic       s1_last_img_reg;
    logic       out_valid_reg;
    logic       out_kind_reg;
    logic [7:0] out_red_reg;
    logic [7:0] out_green_reg;
    logic [7:0] out_blue_reg;
    logic       out_last_run_reg;
    logic       out_last_img_reg;

    logic             adv;
    logic             iterate;
    logic [BPL_W-1:0] bpl_eff;
    logic [BPL_W-1:0] wlim;
    logic [7:0]       cur_data;
    logic [CNT_W-1:0] cur_rem;
    logic             final_plane;
    logic             pos_ok;
    logic             store_wr;
    logic             emit;
    logic [BPL_W:0]   pos_inc;
    logic [BPL_W:0]   pos_n;
    logic             endline;
    logic             at_wlim_end;
    logic             rem_one;
    logic             last_img;
    logic             last_run;

    assign adv     = !out_valid_reg || out_ch.ready;
    assign iterate = cmd.expand || cmd.step;

    always_comb
    begin
        if (bpl_reg == '0)
            bpl_eff = BPL_W'(1);
        else if (int'(bpl_reg) > MAX_LINE_BYTES)
            bpl_eff = BPL_W'(MAX_LINE_BYTES);
        else
            bpl_eff = bpl_reg;
    end

    assign wlim        = (width_reg < bpl_eff) ? width_reg : bpl_eff;
    assign cur_data    = cmd.step ? data_reg : data_byte;
    assign cur_rem     = cmd.step ? rem_reg : (pend_reg ? runcnt_reg : CNT_W'(1));
    assign final_plane = !three_reg || (plane_reg >= 2'd2);
    assign pos_ok      = pos_reg < bpl_eff;
    assign store_wr    = iterate && pos_ok && three_reg && (plane_reg < 2'd2);
    assign emit        = iterate && pos_ok && final_plane && (pos_reg < wlim);
    assign pos_inc     = {1'b0, pos_reg} + (BPL_W + 1)'(1);
    // a stale position past the line end is dropped without advancing
    assign pos_n       = pos_ok ? pos_inc : {1'b0, pos_reg};
    assign endline     = pos_n >= {1'b0, bpl_eff};
    assign at_wlim_end = pos_inc == {1'b0, wlim};
    assign rem_one     = cur_rem == CNT_W'(1);
    assign last_img    = (({1'b0, lines_reg} + (HGT_W + 1)'(1)) == {1'b0, height_reg})
                         && at_wlim_end;
    // emitted positions are contiguous, so the last one is at the width or the final count
    assign last_run    = rem_one || at_wlim_end;

    assign stat.adv       = adv;
    assign stat.blocked   = halt_reg || (lines_reg >= height_reg);
    assign stat.pending   = pend_reg;
    assign stat.marker    = data_byte[7:6] == MARKER_TAG;
    assign stat.zero_cnt  = data_byte[CNT_W-1:0] == '0;
    assign stat.iter_done = endline || rem_one;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpl_reg    <= BPL_W'(1);
            width_reg  <= BPL_W'(1);
            height_reg <= HGT_W'(1);
            three_reg  <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.reg_index)
                CFG_BPL:    bpl_reg    <= cfg_ch.wdata[BPL_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_ch.wdata[BPL_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_ch.wdata[HGT_W-1:0];
                CFG_THREE:  three_reg  <= cfg_ch.wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            plane_reg  <= '0;
            lines_reg  <= '0;
            pend_reg   <= 1'b0;
            runcnt_reg <= '0;
            halt_reg   <= 1'b0;
            rem_reg    <= '0;
        end
        else if (cmd.start)
        begin
            pos_reg    <= '0;
            plane_reg  <= '0;
            lines_reg  <= '0;
            pend_reg   <= 1'b0;
            runcnt_reg <= '0;
            halt_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.set_pend)
            begin
                pend_reg   <= 1'b1;
                runcnt_reg <= data_byte[CNT_W-1:0];
            end
            if (cmd.err)
                halt_reg <= 1'b1;
            if (cmd.expand)
            begin
                pend_reg <= 1'b0;
                rem_reg  <= cur_rem - CNT_W'(1);
            end
            if (cmd.step)
                rem_reg <= rem_reg - CNT_W'(1);
            if (iterate)
            begin
                if (endline)
                begin
                    pos_reg <= '0;
                    if (final_plane)
                    begin
                        plane_reg <= '0;
                        lines_reg <= lines_reg + HGT_W'(1);
                    end
                    else
                        plane_reg <= plane_reg + 2'd1;
                end
                else
                    pos_reg <= pos_n[BPL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.expand)
            data_reg <= data_byte;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pal_wr)
            pal_mem[palette_index] <= palette_color;
        if (iterate)
            pal_q <= pal_mem[cur_data];
    end

    always_ff @(posedge clk)
    begin
        if (store_wr && (plane_reg == 2'd0))
            line0_mem[pos_reg[LINE_AW-1:0]] <= cur_data;
        if (iterate)
            line0_q <= line0_mem[pos_reg[LINE_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (store_wr && (plane_reg == 2'd1))
            line1_mem[pos_reg[LINE_AW-1:0]] <= cur_data;
        if (iterate)
            line1_q <= line1_mem[pos_reg[LINE_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= emit || cmd.err;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // hold both stages while the output transfer stalls
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg     <= cmd.err ? KIND_ERROR : KIND_PIXEL;
            s1_three_reg    <= three_reg;
            s1_blue_reg     <= cur_data;
            s1_last_run_reg <= cmd.err || last_run;
            s1_last_img_reg <= !cmd.err && last_img;
            if (s1_valid_reg)
            begin
                out_kind_reg     <= s1_kind_reg;
                out_last_run_reg <= s1_last_run_reg;
                out_last_img_reg <= s1_last_img_reg;
                if (s1_kind_reg == KIND_ERROR)
                begin
                    out_red_reg   <= '0;
                    out_green_reg <= '0;
                    out_blue_reg  <= '0;
                end
                else if (s1_three_reg)
                begin
                    out_red_reg   <= line0_q;
                    out_green_reg <= line1_q;
                    out_blue_reg  <= s1_blue_reg;
                end
                else
                begin
                    out_red_reg   <= pal_q[23:16];
                    out_green_reg <= pal_q[15:8];
                    out_blue_reg  <= pal_q[7:0];
                end
            end
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.kind          = out_kind_reg;
    assign out_ch.red           = out_red_reg;
    assign out_ch.green         = out_green_reg;
    assign out_ch.blue          = out_blue_reg;
    assign out_ch.last_of_run   = out_last_run_reg;
    assign out_ch.last_of_image = out_last_img_reg;

endmodule

// File: rtl/core/pcx_rle_scanline_decoder.sv
// A pixel passes through the read stage and then the output register after its byte is decoded.
// Input items are taken only while the control is idle and the output is not stalled; a run item
// repeats its byte up to the run count or the end of the current plane before the next item is taken.
// Palette and line store reads are registered, one port each per cycle.
// Reset clears configuration to its defaults and the decoder state, but not the held
// run byte; store contents are kept undefined until written, and no clearing pass runs.
module pcx_rle_scanline_decoder (
    input  logic         clk,
    input  logic         rst_n,
    pcxrle_in_if.sink    in_ch,
    pcxrle_out_if.source out_ch,
    pcxrle_cfg_if.sink   cfg_ch
);
    import pcxrle_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;
    logic     in_ready;

    assign in_ch.ready = in_ready;

    pcxrle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_mode  (in_ch.mode),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    pcxrle_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (in_ch.data_byte),
        .palette_index (in_ch.palette_index),
        .palette_color (in_ch.palette_color),
        .cmd           (cmd),
        .stat          (stat),
        .out_ch        (out_ch),
        .cfg_ch        (cfg_ch)
    );

endmodule

// File: tb/sv/pcx_rle_scanline_decoder_test.sv
module pcx_rle_scanline_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pcxrle_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 1_000_000;
    // covers the longest run (63 bytes) plus the output pipeline
    localparam int DRAIN_CYCLES = 80;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // palette entries the image data draws from; the first five are literals
    localparam int PAL_USED_N    = 8;
    localparam int PAL_LITERAL_N = 5;
    localparam logic [7:0] PAL_USED [PAL_USED_N] =
        '{8'h00, 8'h11, 8'h55, 8'h7F, 8'hBB, 8'hC5, 8'hEE, 8'hFF};

    typedef struct {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_run;
        logic       last_of_image;
    } pixel_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pcxrle_in_if  in_bus ();
    pcxrle_out_if out_bus ();
    pcxrle_cfg_if cfg_bus ();

    pcx_rle_scanline_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus),
        .cfg_ch (cfg_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // decoder image of the block
    logic [BPL_W-1:0] cfg_bpl;
    logic [BPL_W-1:0] cfg_width;
    logic [HGT_W-1:0] cfg_height;
    logic             cfg_three;
    logic [7:0]       line_mem [0:2*MAX_LINE_BYTES-1];
    logic [23:0]      pal_mem [0:PAL_DEPTH-1];
    int unsigned      dec_pos;
    int unsigned      dec_plane;
    logic [HGT_W-1:0] dec_lines;
    bit               run_pend;
    logic [CNT_W-1:0] run_len;
    bit               dec_halted;

    pixel_result_t expected_pixels [$];

    int mismatch_count;
    int items_sent;
    int pixels_seen;
    int errors_seen;
    bit idle_on;
    int hold_cycles;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_literal();
        return PAL_USED[3'($urandom_range(0, PAL_LITERAL_N - 1))];
    endfunction

    function automatic logic [7:0] pick_value();
        return PAL_USED[3'($urandom_range(0, PAL_USED_N - 1))];
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
            $display("%0t: mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic predict_item(input logic [1:0] mode, input logic [7:0] data,
                                input logic [7:0] pidx, input logic [23:0] pcolor);
        int unsigned count;
        int unsigned lim;
        int unsigned wlim;
        int unsigned nplanes;
        int unsigned p;
        int unsigned j;
        bit final_plane;
        bit line_end;
        pixel_result_t r;
        pixel_result_t batch [$];
        case (mode)
            MODE_START:
            begin
                dec_pos    = 0;
                dec_plane  = 0;
                dec_lines  = '0;
                run_pend   = 1'b0;
                run_len    = '0;
                dec_halted = 1'b0;
            end
            MODE_PAL:
                pal_mem[pidx] = pcolor;
            MODE_DATA:
            begin
                if (dec_halted || dec_lines >= cfg_height)
                    return;
                if (run_pend)
                begin
                    count    = 32'(run_len);
                    run_pend = 1'b0;
                end
                else if (data[7:6] == MARKER_TAG)
                begin
                    if (data[5:0] == '0)
                    begin
                        dec_halted = 1'b1;
                        r = '{KIND_ERROR, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0};
                        expected_pixels.push_back(r);
                        return;
                    end
                    run_pend = 1'b1;
                    run_len  = data[5:0];
                    return;
                end
                else
                    count = 1;

                lim = 32'(cfg_bpl);
                if (lim == 0)
                    lim = 1;
                if (lim > MAX_LINE_BYTES)
                    lim = MAX_LINE_BYTES;
                nplanes  = cfg_three ? 3 : 1;
                wlim     = (cfg_width < lim) ? 32'(cfg_width) : lim;
                line_end = 1'b0;
                for (j = 0; j < count && !line_end; j++)
                begin
                    final_plane = (dec_plane + 1 >= nplanes);
                    p = dec_pos;
                    if (p < lim)
                    begin
                        if (cfg_three && dec_plane < 2)
                            line_mem[dec_plane * MAX_LINE_BYTES + p] = data;
                        else if (final_plane && p < wlim)
                        begin
                            r.kind          = KIND_PIXEL;
                            r.last_of_run   = 1'b0;
                            r.last_of_image = (dec_lines + 1 == cfg_height) && (p + 1 == wlim);
                            if (cfg_three)
                            begin
                                r.red   = line_mem[p];
                                r.green = line_mem[MAX_LINE_BYTES + p];
                                r.blue  = data;
                            end
                            else
                                {r.red, r.green, r.blue} = pal_mem[data];
                            batch.push_back(r);
                        end
                        p++;
                    end
                    // past the plane end: drop the rest of the run
                    if (p >= lim)
                    begin
                        dec_pos = 0;
                        if (final_plane)
                        begin
                            dec_plane = 0;
                            dec_lines = dec_lines + 1'b1;
                        end
                        else
                            dec_plane++;
                        line_end = 1'b1;
                    end
                    else
                        dec_pos = p;
                end
            end
            default: ;
        endcase
        if (batch.size() > 0)
        begin
            batch[$].last_of_run = 1'b1;
            foreach (batch[k])
                expected_pixels.push_back(batch[k]);
        end
    endtask

    task automatic send_item(input logic [1:0] mode, input logic [7:0] data,
                             input logic [7:0] pidx, input logic [23:0] pcolor);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.mode          <= mode;
        in_bus.data_byte     <= data;
        in_bus.palette_index <= pidx;
        in_bus.palette_color <= pcolor;
        do
            @(posedge clk);
        while (!in_bus.ready);
        predict_item(mode, data, pidx, pcolor);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_item(MODE_DATA, data, 8'($urandom), 24'($urandom));
    endtask

    task automatic send_start();
        send_item(MODE_START, 8'($urandom), 8'($urandom), 24'($urandom));
    endtask

    task automatic send_palette(input logic [7:0] pidx, input logic [23:0] pcolor);
        send_item(MODE_PAL, 8'($urandom), pidx, pcolor);
    endtask

    task automatic send_run(input logic [CNT_W-1:0] count, input logic [7:0] value);
        send_byte({MARKER_TAG, count});
        send_byte(value);
    endtask

    task automatic write_one(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.wdata     <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            CFG_BPL:    cfg_bpl    = value[BPL_W-1:0];
            CFG_WIDTH:  cfg_width  = value[BPL_W-1:0];
            CFG_HEIGHT: cfg_height = value[HGT_W-1:0];
            CFG_THREE:  cfg_three  = value[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // unused upper bits get random values
    task automatic write_registers(input logic [BPL_W-1:0] bpl, input logic [BPL_W-1:0] width,
                                   input logic [HGT_W-1:0] height, input logic three);
        write_one(CFG_BPL, {4'($urandom), bpl});
        write_one(CFG_WIDTH, {4'($urandom), width});
        write_one(CFG_HEIGHT, height);
        write_one(CFG_THREE, {15'($urandom), three});
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_random_item(input bit long_runs);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        // restart a finished or halted image most of the time
        if ((dec_halted || dec_lines >= cfg_height) && roll < 70)
            send_start();
        else if (long_runs)
        begin
            if (roll < 90)
                send_run(6'($urandom_range(56, 63)), pick_value());
            else
                send_byte(pick_literal());
        end
        else if (roll < 45)
            send_byte(pick_literal());
        else if (roll < 75)
            send_run(6'($urandom_range(1, 63)), pick_value());
        else if (roll < 81)
            send_palette(8'($urandom), 24'($urandom));
        else if (roll < 84)
            send_item(MODE_UNUSED, 8'($urandom), 8'($urandom), 24'($urandom));
        else if (roll < 87)
            send_byte({MARKER_TAG, 6'd0});
        else if (roll < 90)
            send_start();
        else if (roll < 94)
        begin
            // palette write between marker and value
            send_byte({MARKER_TAG, 6'($urandom_range(1, 63))});
            send_palette(8'($urandom), 24'($urandom));
            send_byte(pick_value());
        end
        else
            send_byte(pick_value());
    endtask

    task automatic test_palette_load();
        for (int i = 0; i < PAL_USED_N; i++)
        begin
            if (PAL_USED[i] == 8'h00)
                send_palette(PAL_USED[i], 24'h000000);
            else if (PAL_USED[i] == 8'hFF)
                send_palette(PAL_USED[i], 24'hFFFFFF);
            else
                send_palette(PAL_USED[i], 24'($urandom));
        end
        wait_drained();
    endtask

    task automatic test_one_plane_basics();
        write_registers(12'd4, 12'd3, 16'd2, 1'b0);
        send_start();
        send_byte(8'h00);
        send_byte(8'hBB);
        send_item(MODE_UNUSED, 8'hC1, 8'h00, 24'h000000);
        send_byte({MARKER_TAG, 6'd2});
        send_palette(8'hFF, 24'h5AC33C);
        send_byte(8'hFF);
        send_run(6'd63, 8'h11);
        send_byte(8'h01);
        send_start();
        send_byte({MARKER_TAG, 6'd0});
        send_byte(8'h05);
        send_start();
        wait_drained();
    endtask

    task automatic test_three_plane_basics();
        write_registers(12'd3, 12'd2, 16'd1, 1'b1);
        send_start();
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h30);
        send_run(6'd3, 8'h40);
        send_byte(8'h50);
        send_run(6'd5, 8'h60);
        wait_drained();
    endtask

    // leave the decoder mid-plane, then shrink the line and drop to one plane
    task automatic test_register_changes();
        write_registers(12'd4, 12'd4, 16'd2, 1'b1);
        send_start();
        send_run(6'd6, 8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        wait_drained();
        write_registers(12'd0, 12'd3, 16'd2, 1'b0);
        send_byte(8'h44);
        send_byte(8'h55);
        wait_drained();
    endtask

    task automatic test_random_streams();
        logic [BPL_W-1:0] bpl;
        logic [BPL_W-1:0] width;
        logic [HGT_W-1:0] height;
        logic             three;
        int               n_items;
        bit               long_runs;
        for (int ph = 0; ph < 7; ph++)
        begin
            long_runs = 1'b0;
            n_items   = 3;
            case (ph)
                0:
                begin
                    bpl = 12'd1; width = 12'd1; height = 16'd1; three = 1'b0; n_items = 4;
                end
                1:
                begin
                    bpl = 12'd2048; width = 12'd2048; height = 16'd1; three = 1'b0;
                    n_items = 10; long_runs = 1'b1;
                end
                2:
                begin
                    bpl = 12'd4095; width = 12'd7; height = 16'hFFFF; three = 1'b0;
                    n_items = 6; long_runs = 1'b1;
                end
                3:
                begin
                    bpl = 12'd0; width = 12'd2; height = 16'd3; three = 1'b0; n_items = 6;
                end
                4:
                begin
                    bpl = 12'd5; width = 12'd0; height = 16'd0; three = 1'b1; n_items = 3;
                end
                default:
                begin
                    three  = 1'($urandom_range(0, 1));
                    bpl    = 12'($urandom_range(1, 8));
                    width  = 12'($urandom_range(1, int'(bpl) + 2));
                    height = 16'($urandom_range(1, 4));
                end
            endcase
            write_registers(bpl, width, height, three);
            idle_on = ($urandom_range(0, 3) != 0);
            // one-plane phases without long runs may continue from stale state
            if (three || long_runs || $urandom_range(0, 2) != 0)
                send_start();
            repeat (n_items) send_random_item(long_runs);
            wait_drained();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        write_registers(12'd16, 12'd16, 16'd100, 1'b0);
        send_start();
        idle_on     = 1'b0;
        hold_cycles = 300;
        repeat (10) send_byte(pick_literal());
        idle_on = 1'b1;
        wait_drained();
    endtask

    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left    = 0;
        out_bus.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_bus.ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_bus.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        pixel_result_t got;
        pixel_result_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            got.kind          = out_bus.kind;
            got.red           = out_bus.red;
            got.green         = out_bus.green;
            got.blue          = out_bus.blue;
            got.last_of_run   = out_bus.last_of_run;
            got.last_of_image = out_bus.last_of_image;
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d rgb %02h%02h%02h",
                                          got.kind, got.red, got.green, got.blue));
            else
            begin
                want = expected_pixels.pop_front();
                if (want.kind == KIND_ERROR)
                    errors_seen++;
                else
                    pixels_seen++;
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("kind got %0d expected %0d",
                                              got.kind, want.kind));
                if (got.red !== want.red)
                    report_mismatch($sformatf("red got %02h expected %02h",
                                              got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green got %02h expected %02h",
                                              got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("blue got %02h expected %02h",
                                              got.blue, want.blue));
                if (got.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run got %0d expected %0d",
                                              got.last_of_run, want.last_of_run));
                if (got.last_of_image !== want.last_of_image)
                    report_mismatch($sformatf("last_of_image got %0d expected %0d",
                                              got.last_of_image, want.last_of_image));
            end
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results outstanding", expected_pixels.size());
        $display("pcx_rle_scanline_decoder_test failed");
        $finish;
    end

    initial
    begin
        in_bus.valid          <= 1'b0;
        in_bus.mode           <= MODE_DATA;
        in_bus.data_byte      <= '0;
        in_bus.palette_index  <= '0;
        in_bus.palette_color  <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.reg_index     <= CFG_BPL;
        cfg_bus.wdata         <= '0;
        cfg_bpl        = 12'd1;
        cfg_width      = 12'd1;
        cfg_height     = 16'd1;
        cfg_three      = 1'b0;
        dec_pos        = 0;
        dec_plane      = 0;
        dec_lines      = '0;
        run_pend       = 1'b0;
        run_len        = '0;
        dec_halted     = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        pixels_seen    = 0;
        errors_seen    = 0;
        idle_on        = 1'b1;
        hold_cycles    = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_palette_load();
        test_one_plane_basics();
        test_three_plane_basics();
        test_register_changes();
        test_random_streams();
        test_backpressure();

        $display("sent %0d items; checked %0d pixels and %0d zero-count errors",
                 items_sent, pixels_seen, errors_seen);
        $display("one and three planes, line lengths 0 to 4095, stale state, output hold-off");
        if (mismatch_count == 0)
            $display("pcx_rle_scanline_decoder_test passed");
        else
            $display("pcx_rle_scanline_decoder_test failed");
        $finish;
    end

endmodule

// File: pcx_rle_scanline_decoder.f
rtl/core/pcxrle_pkg.sv
rtl/core/pcxrle_if.sv
rtl/core/pcxrle_ctrl.sv
rtl/core/pcxrle_datapath.sv
rtl/core/pcx_rle_scanline_decoder.sv
tb/sv/pcx_rle_scanline_decoder_test.sv
